### rtl/pm0_pkg.sv
// ----------------------------------------------------------------------------
// pm0_pkg
// Shared constants for the PM/0 stack machine execute unit: opcodes, opr
// sub-codes, status codes and default sizes.
// ----------------------------------------------------------------------------
package pm0_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 2048;
  localparam int unsigned CODE_DEPTH_DEF  = 512;
  localparam int unsigned WORD_W          = 32;

  localparam logic [3:0] OP_LIT   = 4'd1;
  localparam logic [3:0] OP_OPR   = 4'd2;
  localparam logic [3:0] OP_LOD   = 4'd3;
  localparam logic [3:0] OP_STO   = 4'd4;
  localparam logic [3:0] OP_CAL   = 4'd5;
  localparam logic [3:0] OP_INC   = 4'd6;
  localparam logic [3:0] OP_JMP   = 4'd7;
  localparam logic [3:0] OP_JPC   = 4'd8;
  localparam logic [3:0] OP_WRITE = 4'd9;
  localparam logic [3:0] OP_READ  = 4'd10;
  localparam logic [3:0] OP_HALT  = 4'd11;

  localparam logic signed [31:0] OPR_RET = 32'sd0;
  localparam logic signed [31:0] OPR_NEG = 32'sd1;
  localparam logic signed [31:0] OPR_ADD = 32'sd2;
  localparam logic signed [31:0] OPR_SUB = 32'sd3;
  localparam logic signed [31:0] OPR_MUL = 32'sd4;
  localparam logic signed [31:0] OPR_DIV = 32'sd5;
  localparam logic signed [31:0] OPR_ODD = 32'sd6;
  localparam logic signed [31:0] OPR_MOD = 32'sd7;
  localparam logic signed [31:0] OPR_EQL = 32'sd8;
  localparam logic signed [31:0] OPR_NEQ = 32'sd9;
  localparam logic signed [31:0] OPR_LSS = 32'sd10;
  localparam logic signed [31:0] OPR_LEQ = 32'sd11;
  localparam logic signed [31:0] OPR_GTR = 32'sd12;
  localparam logic signed [31:0] OPR_GEQ = 32'sd13;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_RET  = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

endpackage

### rtl/pm0_stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// pm0_stack_machine_execute_unit
// PM/0 P-machine executing one instruction per transaction on a data stack
// held in a single-port synchronous RAM.
// ----------------------------------------------------------------------------
// An instruction is taken when start is high and busy is low; its result
// appears for one cycle with out_strobe and cannot be held off. Every access
// to the stack RAM goes through its one port, one word a cycle: lod, sto and
// cal read the stack once per static-link level, a call writes a four-word
// frame, and div or mod wait on the bit-serial divider. After reset busy
// stays high while the stack is cleared to zero.
// ----------------------------------------------------------------------------
module pm0_stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH = pm0_pkg::STACK_DEPTH_DEF,
  parameter int unsigned CODE_DEPTH  = pm0_pkg::CODE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [3:0]                     in_opcode,
  input  logic [3:0]                     in_level,
  input  logic signed [31:0]             in_operand,
  input  logic signed [31:0]             in_read_value,
  output logic                           out_strobe,
  output logic [$clog2(CODE_DEPTH)-1:0]  out_next_pc,
  output logic [$clog2(STACK_DEPTH)-1:0] out_stack_ptr,
  output logic [$clog2(STACK_DEPTH)-1:0] out_base_ptr,
  output logic signed [31:0]             out_top_value,
  output logic signed [31:0]             out_out_value,
  output logic                           out_out_valid,
  output logic [1:0]                     out_status
);

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned CAW = $clog2(CODE_DEPTH);
  localparam int unsigned XW  = 34;

  localparam logic signed [31:0] OPR_ADD_L = pm0_pkg::OPR_ADD;
  localparam logic signed [31:0] OPR_GEQ_L = pm0_pkg::OPR_GEQ;

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_PRE     = 12'b0000_0000_0100,
    S_WALK    = 12'b0000_0000_1000,
    S_WALK_WT = 12'b0000_0001_0000,
    S_RDA     = 12'b0000_0010_0000,
    S_RDB     = 12'b0000_0100_0000,
    S_EXEC    = 12'b0000_1000_0000,
    S_DIVW    = 12'b0001_0000_0000,
    S_WRITE   = 12'b0010_0000_0000,
    S_TOP_RD  = 12'b0100_0000_0000,
    S_TOP_WT  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]         op_r;
  logic [3:0]         lv_cnt_r;
  logic signed [31:0] m_r;
  logic [31:0]        rv_r;
  logic [CAW-1:0]     pc_r, np_r;
  logic [SAW-1:0]     sp_r, bp_r, sp_n_r, bp_n_r;
  logic [1:0]         status_r, st_n_r;
  logic               fault_r;
  logic               valid_r;
  logic [31:0]        ov_r;
  logic [31:0]        b_r;
  logic [31:0]        a_r;
  logic               two_r;
  logic [SAW-1:0]     addr_a_r, addr_b_r, tgt_r;
  logic [31:0]        wd_r [4];
  logic [SAW-1:0]     wr_base_r;
  logic [2:0]         wr_n_r, wr_idx_r;
  logic [SAW-1:0]     clr_r;
  logic               strobe_r;

  logic               mem_we;
  logic [SAW-1:0]     mem_addr;
  logic [31:0]        mem_wdata, mem_rdata;

  logic               div_start, div_done;
  logic [31:0]        div_quo, div_rem;

  function automatic logic in_stk(logic signed [XW-1:0] x);
    return !x[XW-1] && (x < $signed(XW'(STACK_DEPTH)));
  endfunction

  function automatic logic in_cod(logic signed [XW-1:0] x);
    return !x[XW-1] && (x < $signed(XW'(CODE_DEPTH)));
  endfunction

  logic signed [XW-1:0] sp_x, bp_x, m_x, b_x, b_nx, bm_x, first_x, second_x;
  logic [CAW-1:0]       np_inc;
  logic                 is_bin, is_walk, pre_fault, pre_outer;
  logic                 walk_fault, plan_rd, plan_two;
  logic [SAW-1:0]       plan_a, plan_b;
  logic [31:0]          first, second;
  logic signed [31:0]   fs, ss;
  logic [31:0]          alu;

  assign sp_x     = $signed({{(XW-SAW){1'b0}}, sp_r});
  assign bp_x     = $signed({{(XW-SAW){1'b0}}, bp_r});
  assign m_x      = {{(XW-32){m_r[31]}}, m_r};
  assign b_x      = $signed({{(XW-32){b_r[31]}}, b_r});
  assign b_nx     = b_x + 34'sd1;
  assign bm_x     = b_x + m_x;
  assign np_inc   = (pc_r == CAW'(CODE_DEPTH - 1)) ? '0 : pc_r + CAW'(1);
  assign is_bin   = (m_r inside {[OPR_ADD_L:OPR_GEQ_L]}) && (m_r != pm0_pkg::OPR_ODD);
  assign is_walk  = (op_r == pm0_pkg::OP_LOD) || (op_r == pm0_pkg::OP_STO) ||
                    (op_r == pm0_pkg::OP_CAL);
  assign pre_outer = (op_r == pm0_pkg::OP_OPR) && (m_r == pm0_pkg::OPR_RET) &&
                     (bp_r == SAW'(1));

  always_comb begin
    pre_fault = 1'b0;
    case (op_r)
      pm0_pkg::OP_LIT, pm0_pkg::OP_READ, pm0_pkg::OP_LOD: begin
        pre_fault = !in_stk(sp_x + 34'sd1);
      end
      pm0_pkg::OP_OPR: begin
        if (m_r == pm0_pkg::OPR_RET) begin
          pre_fault = (bp_r == '0) || !in_stk(bp_x + 34'sd3);
        end else if (is_bin) begin
          pre_fault = (sp_r == '0);
        end
      end
      pm0_pkg::OP_STO, pm0_pkg::OP_JPC, pm0_pkg::OP_WRITE: begin
        pre_fault = (sp_r == '0);
      end
      pm0_pkg::OP_CAL: begin
        pre_fault = !in_stk(sp_x + 34'sd4) || !in_cod(m_x);
      end
      pm0_pkg::OP_INC: begin
        pre_fault = !in_stk(sp_x + m_x);
      end
      pm0_pkg::OP_JMP: begin
        pre_fault = !in_cod(m_x);
      end
      default: begin
        pre_fault = 1'b0;
      end
    endcase
  end

  always_comb begin
    walk_fault = 1'b0;
    plan_rd    = 1'b0;
    plan_two   = 1'b0;
    plan_a     = sp_r;
    plan_b     = sp_r;
    if (lv_cnt_r != '0) begin
      walk_fault = !in_stk(b_nx);
    end else begin
      case (op_r)
        pm0_pkg::OP_LOD: begin
          walk_fault = !in_stk(bm_x);
          plan_rd    = 1'b1;
          plan_a     = bm_x[SAW-1:0];
        end
        pm0_pkg::OP_STO: begin
          walk_fault = !in_stk(bm_x);
          plan_rd    = 1'b1;
        end
        pm0_pkg::OP_OPR: begin
          if (m_r == pm0_pkg::OPR_RET) begin
            plan_rd  = 1'b1;
            plan_two = 1'b1;
            plan_a   = bp_r + SAW'(3);
            plan_b   = bp_r + SAW'(2);
          end else if ((m_r == pm0_pkg::OPR_NEG) || (m_r == pm0_pkg::OPR_ODD)) begin
            plan_rd = 1'b1;
          end else if (is_bin) begin
            plan_rd  = 1'b1;
            plan_two = 1'b1;
            plan_a   = sp_r - SAW'(1);
          end
        end
        pm0_pkg::OP_JPC, pm0_pkg::OP_WRITE: begin
          plan_rd = 1'b1;
        end
        default: begin
          plan_rd = 1'b0;
        end
      endcase
    end
  end

  assign first    = two_r ? a_r : mem_rdata;
  assign second   = mem_rdata;
  assign fs       = $signed(first);
  assign ss       = $signed(second);
  assign first_x  = {{(XW-32){first[31]}}, first};
  assign second_x = {{(XW-32){second[31]}}, second};

  always_comb begin
    case (m_r)
      pm0_pkg::OPR_ADD: alu = first + second;
      pm0_pkg::OPR_SUB: alu = first - second;
      pm0_pkg::OPR_MUL: alu = first * second;
      pm0_pkg::OPR_EQL: alu = {31'd0, fs == ss};
      pm0_pkg::OPR_NEQ: alu = {31'd0, fs != ss};
      pm0_pkg::OPR_LSS: alu = {31'd0, fs < ss};
      pm0_pkg::OPR_LEQ: alu = {31'd0, fs <= ss};
      pm0_pkg::OPR_GTR: alu = {31'd0, fs > ss};
      default:          alu = {31'd0, fs >= ss};
    endcase
  end

  logic           ex_fault, ex_div, ex_valid;
  logic [2:0]     ex_wr_n;
  logic [SAW-1:0] ex_base, ex_sp, ex_bp;
  logic [CAW-1:0] ex_np;
  logic [31:0]    ex_wd0, ex_ov;

  always_comb begin
    ex_fault = 1'b0;
    ex_div   = 1'b0;
    ex_valid = 1'b0;
    ex_wr_n  = 3'd0;
    ex_base  = sp_r;
    ex_sp    = sp_r;
    ex_bp    = bp_r;
    ex_np    = np_r;
    ex_wd0   = first;
    ex_ov    = '0;
    case (op_r)
      pm0_pkg::OP_LIT, pm0_pkg::OP_READ: begin
        ex_wr_n = 3'd1;
        ex_base = sp_r + SAW'(1);
        ex_wd0  = (op_r == pm0_pkg::OP_LIT) ? m_r : rv_r;
        ex_sp   = sp_r + SAW'(1);
      end
      pm0_pkg::OP_OPR: begin
        if (m_r == pm0_pkg::OPR_RET) begin
          if (!in_cod(first_x) || !in_stk(second_x)) begin
            ex_fault = 1'b1;
          end else begin
            ex_sp = bp_r - SAW'(1);
            ex_np = first[CAW-1:0];
            ex_bp = second[SAW-1:0];
          end
        end else if (m_r == pm0_pkg::OPR_NEG) begin
          ex_wr_n = 3'd1;
          ex_wd0  = 32'd0 - first;
        end else if (m_r == pm0_pkg::OPR_ODD) begin
          ex_wr_n = 3'd1;
          ex_wd0  = {31'd0, first[0]};
        end else if (is_bin) begin
          ex_base = sp_r - SAW'(1);
          ex_sp   = sp_r - SAW'(1);
          if ((m_r == pm0_pkg::OPR_DIV) || (m_r == pm0_pkg::OPR_MOD)) begin
            if (second == '0) begin
              ex_fault = 1'b1;
            end else begin
              ex_div = 1'b1;
            end
          end else begin
            ex_wr_n = 3'd1;
            ex_wd0  = alu;
          end
        end
      end
      pm0_pkg::OP_LOD: begin
        ex_wr_n = 3'd1;
        ex_base = sp_r + SAW'(1);
        ex_sp   = sp_r + SAW'(1);
      end
      pm0_pkg::OP_STO: begin
        ex_wr_n = 3'd1;
        ex_base = tgt_r;
        ex_sp   = sp_r - SAW'(1);
      end
      pm0_pkg::OP_CAL: begin
        ex_wr_n = 3'd4;
        ex_base = sp_r + SAW'(1);
        ex_wd0  = '0;
        ex_bp   = sp_r + SAW'(1);
        ex_np   = m_r[CAW-1:0];
      end
      pm0_pkg::OP_INC: begin
        ex_sp = sp_r + m_r[SAW-1:0];
      end
      pm0_pkg::OP_JMP: begin
        ex_np = m_r[CAW-1:0];
      end
      pm0_pkg::OP_JPC: begin
        ex_sp = sp_r - SAW'(1);
        if (first == '0) begin
          if (!in_cod(m_x)) begin
            ex_fault = 1'b1;
          end else begin
            ex_np = m_r[CAW-1:0];
          end
        end
      end
      pm0_pkg::OP_WRITE: begin
        ex_valid = 1'b1;
        ex_ov    = first;
        ex_sp    = sp_r - SAW'(1);
      end
      default: begin
        ex_fault = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (clr_r == SAW'(STACK_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:    if (start) state_nxt = S_PRE;
      S_PRE: begin
        if (status_r != pm0_pkg::ST_RUN) begin
          state_nxt = S_TOP_RD;
        end else if (pre_outer || pre_fault) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_fault) begin
          state_nxt = S_WRITE;
        end else if (lv_cnt_r != '0) begin
          state_nxt = S_WALK_WT;
        end else if (plan_rd) begin
          state_nxt = S_RDA;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_WALK_WT: state_nxt = S_WALK;
      S_RDA:     state_nxt = two_r ? S_RDB : S_EXEC;
      S_RDB:     state_nxt = S_EXEC;
      S_EXEC:    state_nxt = (ex_div && !ex_fault) ? S_DIVW : S_WRITE;
      S_DIVW:    if (div_done) state_nxt = S_WRITE;
      S_WRITE:   if (wr_idx_r >= wr_n_r) state_nxt = S_TOP_RD;
      S_TOP_RD:  state_nxt = S_TOP_WT;
      S_TOP_WT:  state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = sp_r;
    mem_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
      end
      S_WALK:  mem_addr = b_nx[SAW-1:0];
      S_RDA:   mem_addr = addr_a_r;
      S_RDB:   mem_addr = addr_b_r;
      S_WRITE: begin
        mem_we    = (wr_idx_r < wr_n_r);
        mem_addr  = wr_base_r + SAW'(wr_idx_r);
        mem_wdata = wd_r[wr_idx_r[1:0]];
      end
      default: mem_addr = sp_r;
    endcase
  end

  assign div_start = (state_r == S_EXEC) && ex_div && !ex_fault;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      pc_r     <= '0;
      bp_r     <= SAW'(1);
      sp_r     <= '0;
      status_r <= pm0_pkg::ST_RUN;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= 1'b0;
      case (state_r)
        S_CLEAR: clr_r <= clr_r + SAW'(1);
        S_IDLE: begin
          if (start) begin
            op_r <= in_opcode;
            lv_cnt_r <= in_level;
            m_r  <= in_operand;
            rv_r <= in_read_value;
          end
        end
        S_PRE: begin
          np_r     <= np_inc;
          sp_n_r   <= sp_r;
          bp_n_r   <= bp_r;
          st_n_r   <= (op_r == pm0_pkg::OP_HALT) ? pm0_pkg::ST_HALT : pm0_pkg::ST_RUN;
          fault_r  <= pre_fault && !pre_outer;
          valid_r  <= 1'b0;
          ov_r     <= '0;
          wr_n_r   <= '0;
          wr_idx_r <= '0;
          b_r      <= 32'(bp_r);
          if (!is_walk) begin
            lv_cnt_r <= '0;
          end
          if (pre_outer) begin
            np_r   <= '0;
            sp_n_r <= '0;
            bp_n_r <= '0;
            st_n_r <= pm0_pkg::ST_RET;
          end
        end
        S_WALK: begin
          fault_r  <= walk_fault;
          two_r    <= plan_two;
          addr_a_r <= plan_a;
          addr_b_r <= plan_b;
          tgt_r    <= bm_x[SAW-1:0];
        end
        S_WALK_WT: begin
          b_r      <= mem_rdata;
          lv_cnt_r <= lv_cnt_r - 4'd1;
        end
        S_RDB: a_r <= mem_rdata;
        S_EXEC: begin
          fault_r   <= ex_fault;
          wr_n_r    <= ex_fault ? 3'd0 : ex_wr_n;
          wr_base_r <= ex_base;
          wd_r[0]   <= ex_wd0;
          wd_r[1]   <= b_r;
          wd_r[2]   <= 32'(bp_r);
          wd_r[3]   <= 32'(np_r);
          sp_n_r    <= ex_sp;
          bp_n_r    <= ex_bp;
          np_r      <= ex_np;
          valid_r   <= ex_valid && !ex_fault;
          ov_r      <= ex_ov;
        end
        S_DIVW: begin
          if (div_done) begin
            wd_r[0] <= (m_r == pm0_pkg::OPR_MOD) ? div_rem : div_quo;
            wr_n_r  <= 3'd1;
          end
        end
        S_WRITE: begin
          if (wr_idx_r < wr_n_r) begin
            wr_idx_r <= wr_idx_r + 3'd1;
          end else if (fault_r) begin
            status_r <= pm0_pkg::ST_ERR;
            valid_r  <= 1'b0;
          end else begin
            pc_r     <= np_r;
            sp_r     <= sp_n_r;
            bp_r     <= bp_n_r;
            status_r <= st_n_r;
          end
        end
        S_TOP_WT: begin
          strobe_r      <= 1'b1;
          out_next_pc   <= pc_r;
          out_stack_ptr <= sp_r;
          out_base_ptr  <= bp_r;
          out_top_value <= mem_rdata;
          out_out_value <= valid_r ? ov_r : '0;
          out_out_valid <= valid_r;
          out_status    <= status_r;
        end
        default: begin
        end
      endcase
    end
  end

  pm0_ram #(
    .WIDTH (pm0_pkg::WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  pm0_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  ($signed(a_r)),
    .divisor   ($signed(mem_rdata)),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("stack write while idle");

  a_valid_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_out_valid) |-> (out_status == pm0_pkg::ST_RUN))
    else $error("write value reported while stopped");

  a_status_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r != pm0_pkg::ST_RUN) |=> (status_r == $past(status_r)))
    else $error("status left a stopped state");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_TOP_WT))
    else $error("result strobe without top read");

endmodule

### rtl/pm0_ram.sv
// ----------------------------------------------------------------------------
// pm0_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pm0_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/pm0_div.sv
// ----------------------------------------------------------------------------
// pm0_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero; remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module pm0_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [31:0]  dividend,
  input  logic signed [31:0]  divisor,
  output logic                done,
  output logic [31:0]         quotient,
  output logic [31:0]         remainder
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic        neg_q_r;
  logic        neg_r_r;
  logic [32:0] shifted;
  logic [32:0] trial;

  assign shifted = {rem_r, quo_r[31]};
  assign trial   = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= 5'd31;
        quo_r   <= dividend[31] ? 32'(-dividend) : 32'(dividend);
        den_r   <= divisor[31] ? 32'(-divisor) : 32'(divisor);
        rem_r   <= '0;
        neg_q_r <= dividend[31] ^ divisor[31];
        neg_r_r <= dividend[31];
      end else if (busy_r) begin
        if (!trial[32]) begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= shifted[31:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = neg_q_r ? (32'd0 - quo_r) : quo_r;
  assign remainder = neg_r_r ? (32'd0 - rem_r) : rem_r;

endmodule
